// ===== rtl/vgf_pkg.sv =====
`timescale 1ns / 1ps
package vgf_pkg;

  // classified text byte handed from front to back
  typedef struct packed {
    logic [7:0] text_byte;
    logic       eoi;
    logic       is_nl;
    logic       is_tab;
    logic       is_colon;
    logic       is_hash;
    logic       is_digit;
    logic       is_sep;
    logic       is_g;
    logic       is_t;
    logic [3:0] digit;
  } item_t;

  // byte queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // configuration register indexes
  localparam logic [2:0] REG_STRICT_MODE = 3'd0;
  localparam logic [2:0] REG_QUERY_LOW   = 3'd1;
  localparam logic [2:0] REG_QUERY_HIGH  = 3'd2;
  localparam logic [2:0] REG_QUERY_TEXT  = 3'd3;
  localparam logic [2:0] REG_QUERY_LEN   = 3'd4;

  // line status codes
  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_MATCHED  = 3'd1;
  localparam logic [2:0] ST_NO_MATCH = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_NO_GT    = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;

  // allele parser phases
  localparam logic [2:0] PH_FIRST_START  = 3'd0;
  localparam logic [2:0] PH_FIRST        = 3'd1;
  localparam logic [2:0] PH_SECOND_START = 3'd2;
  localparam logic [2:0] PH_SECOND       = 3'd3;
  localparam logic [2:0] PH_BAD          = 3'd4;

  // GT token scan in FORMAT
  localparam logic [1:0] GT_IDLE = 2'd0;
  localparam logic [1:0] GT_G    = 2'd1;
  localparam logic [1:0] GT_GT   = 2'd2;
  localparam logic [1:0] GT_BAD  = 2'd3;

  // #CHROM prefix tracking
  localparam logic [2:0] CHROM_LEN  = 3'd6;
  localparam logic [2:0] CHROM_FAIL = 3'd7;

  // fields before the samples
  localparam logic [3:0] FORMAT_FIELD = 4'd8;
  localparam logic [3:0] SAMPLE_FIELD = 4'd9;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic [7:0] chrom_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = CH_HASH;
      3'd1: ch = 8'h43;
      3'd2: ch = 8'h48;
      3'd3: ch = 8'h52;
      3'd4: ch = 8'h4F;
      3'd5: ch = 8'h4D;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/vgf_front.sv =====
`timescale 1ns / 1ps
module vgf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           s_tlast,
  output logic           item_valid,
  input  logic           item_ready,
  output vgf_pkg::item_t item
);
  import vgf_pkg::*;

  item_t cls;

  // byte classification
  always_comb begin
    cls.text_byte = s_tdata;
    cls.eoi       = s_tlast;
    cls.is_nl     = (s_tdata == CH_NL);
    cls.is_tab    = (s_tdata == CH_TAB);
    cls.is_colon  = (s_tdata == CH_COLON);
    cls.is_hash   = (s_tdata == CH_HASH);
    cls.is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    cls.is_sep    = (s_tdata == CH_PIPE) || (s_tdata == CH_SLASH);
    cls.is_g      = (s_tdata == CH_G);
    cls.is_t      = (s_tdata == CH_T);
    cls.digit     = 4'(s_tdata - CH_ZERO);
  end

  assign s_tready = !item_valid || item_ready;

  // one register stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= cls;
    end
  end

endmodule

// ===== rtl/vgf_queue.sv =====
`timescale 1ns / 1ps
module vgf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  vgf_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output vgf_pkg::item_t rd_item
);
  import vgf_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != (QAW+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vgf_back.sv =====
`timescale 1ns / 1ps
module vgf_back #(
  parameter int QUERY_BYTES         = 8,
  parameter int ALLELE_BITS         = 16,
  parameter int SUBFIELD_INDEX_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  input  logic           item_valid,
  output logic           item_ready,
  input  vgf_pkg::item_t item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata
);
  import vgf_pkg::*;

  localparam int AB  = ALLELE_BITS;
  localparam int SIB = SUBFIELD_INDEX_BITS;
  localparam int MW  = (AB > 16) ? AB : 16;
  localparam logic [SIB-1:0] SUB_MAX = {SIB{1'b1}};
  localparam logic [3:0] QB = 4'(QUERY_BYTES);

  // configuration registers
  logic                     strict_mode;
  logic signed [16:0]       query_low;
  logic signed [16:0]       query_high;
  logic [8*QUERY_BYTES-1:0] query_text;
  logic [3:0]               query_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode  <= 1'b0;
      query_low    <= 17'sd0;
      query_high   <= 17'sd1;
      query_text   <= '0;
      query_length <= 4'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRICT_MODE: strict_mode  <= cfg_data[0];
        REG_QUERY_LOW:   query_low    <= cfg_data[16:0];
        REG_QUERY_HIGH:  query_high   <= cfg_data[16:0];
        REG_QUERY_TEXT:  query_text   <= cfg_data[8*QUERY_BYTES-1:0];
        REG_QUERY_LEN:   query_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // query values as used by the compare
  logic [3:0]         eff_qlen;
  logic signed [16:0] q_lo;
  logic signed [16:0] q_hi;

  assign eff_qlen = (query_length > QB) ? QB : query_length;
  assign q_lo     = (query_low > query_high) ? query_high : query_low;
  assign q_hi     = (query_low > query_high) ? query_low : query_high;

  // line state
  logic           chrom_seen, chrom_seen_next;
  logic           halted, halted_next;
  logic           line_started, line_started_next;
  logic           line_is_header, line_is_header_next;
  logic [2:0]     chrom_prog, chrom_prog_next;
  logic [3:0]     tab_num, tab_num_next;
  logic [SIB-1:0] colon_num, colon_num_next;
  logic [1:0]     gt_tok, gt_tok_next;
  logic           gt_found, gt_found_next;
  logic [SIB-1:0] gt_idx, gt_idx_next;
  logic [2:0]     phase, phase_next;
  logic [AB-1:0]  allele1, allele1_next;
  logic [AB-1:0]  allele2, allele2_next;
  logic [3:0]     spos, spos_next;
  logic           seq, seq_next;
  logic           matched, matched_next;
  logic           last_tab, last_tab_next;

  // result register
  logic       keep_line;
  logic [2:0] line_status;
  logic       res_emit;
  logic       res_keep;
  logic [2:0] res_status;
  logic       step;

  assign item_ready = !m_tvalid || m_tready;
  assign step       = item_valid && item_ready;
  assign m_tdata    = {4'b0000, line_status, keep_line};

  // does the genotype subfield just closed match the query
  function automatic logic sample_match(input logic [3:0] p, input logic eq,
                                        input logic [2:0] ph, input logic [AB-1:0] a,
                                        input logic [AB-1:0] b);
    logic [AB-1:0] lo;
    logic [AB-1:0] hi;
    logic          hit;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (p == 4'd0) begin
      hit = 1'b0;
    end else if (strict_mode) begin
      hit = eq && (p == eff_qlen);
    end else begin
      hit = (ph == PH_SECOND) && !q_lo[16] && !q_hi[16] &&
            (MW'(lo) == MW'(q_lo[15:0])) && (MW'(hi) == MW'(q_hi[15:0]));
    end
    return hit;
  endfunction

  // query byte at the current sample position
  function automatic logic [7:0] query_byte(input logic [3:0] p);
    logic [7:0] qb;
    qb = 8'h00;
    for (int i = 0; i < QUERY_BYTES; i++) begin
      if (p == 4'(i)) begin
        qb = query_text[8*i +: 8];
      end
    end
    return qb;
  endfunction

  logic              hdr;
  logic              hlt;
  logic              in_sample;
  logic              close_gt;
  logic              close_hit;
  logic              fin_gt;
  logic              fin_hit;
  logic [AB+3:0]     acc;
  logic [AB-1:0]     acc_src;

  always_comb begin
    chrom_seen_next     = chrom_seen;
    halted_next         = halted;
    line_started_next   = line_started;
    line_is_header_next = line_is_header;
    chrom_prog_next     = chrom_prog;
    tab_num_next        = tab_num;
    colon_num_next      = colon_num;
    gt_tok_next         = gt_tok;
    gt_found_next       = gt_found;
    gt_idx_next         = gt_idx;
    phase_next          = phase;
    allele1_next        = allele1;
    allele2_next        = allele2;
    spos_next           = spos;
    seq_next            = seq;
    matched_next        = matched;
    last_tab_next       = last_tab;
    res_emit            = 1'b0;
    res_keep            = 1'b0;
    res_status          = ST_HEADER;
    hdr                 = line_is_header;
    hlt                 = halted;

    // subfield close on the state before this byte (tab or colon)
    in_sample = (tab_num >= SAMPLE_FIELD) && gt_found && (colon_num == gt_idx);
    close_gt  = (tab_num == FORMAT_FIELD) && (gt_tok == GT_GT) && !gt_found &&
                (colon_num != SUB_MAX);
    close_hit = in_sample && sample_match(spos, seq, phase, allele1, allele2);

    acc_src = (phase == PH_SECOND_START || phase == PH_SECOND) ? allele2 : allele1;
    acc     = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + (AB+4)'(item.digit);

    if (!item.is_nl) begin
      // first byte decides header or data
      if (!line_started) begin
        line_started_next   = 1'b1;
        hdr                 = item.is_hash;
        line_is_header_next = hdr;
        if (!hdr && !chrom_seen) begin
          hlt = 1'b1;
        end
        halted_next = hlt;
      end

      if (hlt) begin
        // halted: nothing tracked
      end else if (hdr) begin
        if (chrom_prog < CHROM_LEN) begin
          if (item.text_byte == chrom_char(chrom_prog)) begin
            chrom_prog_next = chrom_prog + 3'd1;
            if (chrom_prog == CHROM_LEN - 3'd1) begin
              chrom_seen_next = 1'b1;
            end
          end else begin
            chrom_prog_next = CHROM_FAIL;
          end
        end
      end else if (item.is_tab) begin
        if (tab_num >= FORMAT_FIELD) begin
          if (close_gt) begin
            gt_found_next = 1'b1;
            gt_idx_next   = colon_num;
          end
          if (close_hit) begin
            matched_next = 1'b1;
          end
        end
        if (tab_num < SAMPLE_FIELD) begin
          tab_num_next = tab_num + 4'd1;
        end
        colon_num_next = '0;
        gt_tok_next    = GT_IDLE;
        phase_next     = PH_FIRST_START;
        allele1_next   = '0;
        allele2_next   = '0;
        spos_next      = 4'd0;
        seq_next       = 1'b1;
      end else if (item.is_colon && tab_num >= FORMAT_FIELD) begin
        if (close_gt) begin
          gt_found_next = 1'b1;
          gt_idx_next   = colon_num;
        end
        if (close_hit) begin
          matched_next = 1'b1;
        end
        if (tab_num == FORMAT_FIELD) begin
          gt_tok_next = GT_IDLE;
        end
        if (colon_num != SUB_MAX) begin
          colon_num_next = colon_num + 1'b1;
        end
        phase_next   = PH_FIRST_START;
        allele1_next = '0;
        allele2_next = '0;
        spos_next    = 4'd0;
        seq_next     = 1'b1;
      end else if (tab_num == FORMAT_FIELD) begin
        if (gt_tok == GT_IDLE && item.is_g) begin
          gt_tok_next = GT_G;
        end else if (gt_tok == GT_G && item.is_t) begin
          gt_tok_next = GT_GT;
        end else begin
          gt_tok_next = GT_BAD;
        end
      end else if (in_sample) begin
        // strict byte compare
        if (!(spos < eff_qlen && item.text_byte == query_byte(spos))) begin
          seq_next = 1'b0;
        end
        if (spos != 4'd15) begin
          spos_next = spos + 4'd1;
        end
        // allele parse
        case (phase)
          PH_FIRST_START, PH_FIRST: begin
            if (item.is_digit) begin
              allele1_next = acc[AB-1:0];
              phase_next   = (acc[AB+3:AB] != 4'd0) ? PH_BAD : PH_FIRST;
            end else if (phase == PH_FIRST && item.is_sep) begin
              phase_next = PH_SECOND_START;
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_SECOND_START, PH_SECOND: begin
            if (item.is_digit) begin
              allele2_next = acc[AB-1:0];
              phase_next   = (acc[AB+3:AB] != 4'd0) ? PH_BAD : PH_SECOND;
            end else begin
              phase_next = PH_BAD;
            end
          end
          default: phase_next = PH_BAD;
        endcase
      end
      last_tab_next = item.is_tab;
    end

    // line end: close the last subfield on the updated state
    fin_gt  = gt_found_next ||
              ((tab_num_next == FORMAT_FIELD) && (gt_tok_next == GT_GT) &&
               (colon_num_next != SUB_MAX));
    fin_hit = matched_next ||
              ((tab_num_next >= SAMPLE_FIELD) && gt_found_next &&
               (colon_num_next == gt_idx_next) &&
               sample_match(spos_next, seq_next, phase_next, allele1_next, allele2_next));

    if ((item.is_nl || item.eoi) && line_started_next) begin
      res_emit = 1'b1;
      if (halted_next) begin
        res_status = ST_HALTED;
      end else if (line_is_header_next) begin
        res_status = ST_HEADER;
        res_keep   = 1'b1;
      end else if (tab_num_next < FORMAT_FIELD) begin
        res_status = last_tab_next ? ST_NO_GT : ST_SHORT;
      end else if (!fin_gt) begin
        res_status = ST_NO_GT;
      end else if (fin_hit) begin
        res_status = ST_MATCHED;
        res_keep   = 1'b1;
      end else begin
        res_status = ST_NO_MATCH;
      end
      // clear per-line state
      line_started_next   = 1'b0;
      line_is_header_next = 1'b0;
      chrom_prog_next     = 3'd0;
      tab_num_next        = 4'd0;
      colon_num_next      = '0;
      gt_tok_next         = GT_IDLE;
      gt_found_next       = 1'b0;
      gt_idx_next         = '0;
      matched_next        = 1'b0;
      last_tab_next       = 1'b0;
      phase_next          = PH_FIRST_START;
      allele1_next        = '0;
      allele2_next        = '0;
      spos_next           = 4'd0;
      seq_next            = 1'b1;
    end
  end

  // state update, one byte per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      chrom_seen     <= 1'b0;
      halted         <= 1'b0;
      line_started   <= 1'b0;
      line_is_header <= 1'b0;
      chrom_prog     <= 3'd0;
      tab_num        <= 4'd0;
      colon_num      <= '0;
      gt_tok         <= GT_IDLE;
      gt_found       <= 1'b0;
      gt_idx         <= '0;
      phase          <= PH_FIRST_START;
      allele1        <= '0;
      allele2        <= '0;
      spos           <= 4'd0;
      seq            <= 1'b1;
      matched        <= 1'b0;
      last_tab       <= 1'b0;
    end else if (step) begin
      chrom_seen     <= chrom_seen_next;
      halted         <= halted_next;
      line_started   <= line_started_next;
      line_is_header <= line_is_header_next;
      chrom_prog     <= chrom_prog_next;
      tab_num        <= tab_num_next;
      colon_num      <= colon_num_next;
      gt_tok         <= gt_tok_next;
      gt_found       <= gt_found_next;
      gt_idx         <= gt_idx_next;
      phase          <= phase_next;
      allele1        <= allele1_next;
      allele2        <= allele2_next;
      spos           <= spos_next;
      seq            <= seq_next;
      matched        <= matched_next;
      last_tab       <= last_tab_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_ready) begin
      m_tvalid <= step && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_emit) begin
      keep_line   <= res_keep;
      line_status <= res_status;
    end
  end

endmodule

// ===== rtl/vcf_genotype_line_filter_top.sv =====
`timescale 1ns / 1ps
// VCF genotype line filter. Takes VCF text one byte per transfer on the s_ side
// (s_tlast marks the final byte) and gives one keep/drop decision with a status
// code on the m_ side for every non-empty line, in line order, when the line's
// newline or final byte has passed. The block sustains one byte per clock while
// the m_ side is ready: a classifying input register feeds a four-entry byte
// queue, and the line parser consumes one byte per cycle into an output
// register, except while that register holds an untaken decision.
// Configuration writes on the cfg_ channel are always ready and are registered;
// write them only while no line is in flight.
module vcf_genotype_line_filter_top #(
  parameter int QUERY_BYTES         = 8,
  parameter int ALLELE_BITS         = 16,
  parameter int SUBFIELD_INDEX_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // keep_line, line_status[2:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import vgf_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign cfg_ready = 1'b1;

  vgf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  vgf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  vgf_back #(
    .QUERY_BYTES         (QUERY_BYTES),
    .ALLELE_BITS         (ALLELE_BITS),
    .SUBFIELD_INDEX_BITS (SUBFIELD_INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
